@@ design/u16u8_pkg.sv @@
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and the code point encoder shared by the UTF-16 to UTF-8
// encoder modules.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QLevelW  = $clog2(QDepth + 1);

  localparam logic [15:0] SurLo    = 16'hd800;
  localparam logic [15:0] SurHi    = 16'hdfff;
  localparam logic [15:0] LowSurLo = 16'hdc00;
  localparam logic [20:0] SuppBase = 21'h10000;
  localparam logic [20:0] Lim1     = 21'h00080;
  localparam logic [20:0] Lim2     = 21'h00800;
  localparam logic [20:0] Lim3     = 21'h10000;

  // bytes[0] leaves first
  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
  } cmd_t;

  function automatic cmd_t encode_cp(input logic [20:0] cp);
    cmd_t c;
    c.bytes = '0;
    if (cp < Lim1) begin
      c.cnt      = 3'd1;
      c.bytes[0] = cp[7:0];
    end else if (cp < Lim2) begin
      c.cnt      = 3'd2;
      c.bytes[0] = {3'b110, cp[10:6]};
      c.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < Lim3) begin
      c.cnt      = 3'd3;
      c.bytes[0] = {4'b1110, cp[15:12]};
      c.bytes[1] = {2'b10, cp[11:6]};
      c.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      c.cnt      = 3'd4;
      c.bytes[0] = {5'b11110, cp[20:18]};
      c.bytes[1] = {2'b10, cp[17:12]};
      c.bytes[2] = {2'b10, cp[11:6]};
      c.bytes[3] = {2'b10, cp[5:0]};
    end
    return c;
  endfunction

endpackage

@@ design/u16u8_if.sv @@
// ----------------------------------------------------------------------------
// u16u8_if
// Valid/ready channels: UTF-16 unit input and UTF-8 byte output.
// ----------------------------------------------------------------------------
interface u16u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        string_last;

  modport source (output valid, output code_unit, output string_last, input ready);
  modport sink   (input valid, input code_unit, input string_last, output ready);
endinterface

interface u16u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       run_last;

  modport source (output valid, output utf8_byte, output run_last, input ready);
  modport sink   (input valid, input utf8_byte, input run_last, output ready);
endinterface

@@ design/u16u8_front.sv @@
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts UTF-16 units, tracks a held surrogate and pushes an encoded byte
// group for every unit that produces output.
// ----------------------------------------------------------------------------
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_code_unit,
  input  logic        in_string_last,
  output logic        push_valid,
  input  logic        push_ready,
  output cmd_t        push_cmd
);

  logic       pending_r, pending_nxt;
  logic [9:0] held_r, held_nxt;
  logic       is_sur, is_low, emit;
  logic [20:0] cp;
  logic        accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_sur      = (in_code_unit >= SurLo) && (in_code_unit <= SurHi);
    is_low      = (in_code_unit >= LowSurLo) && (in_code_unit <= SurHi);
    pending_nxt = pending_r;
    held_nxt    = held_r;
    emit        = 1'b1;
    cp          = {5'd0, in_code_unit};
    if (pending_r) begin
      cp = is_low ? ({1'b0, held_r, in_code_unit[9:0]} + SuppBase) : '0;
      if (accept) begin
        pending_nxt = 1'b0;
        held_nxt    = '0;
      end
    end else if (is_sur && !in_string_last) begin
      emit = 1'b0;
      if (accept) begin
        pending_nxt = 1'b1;
        held_nxt    = in_code_unit[9:0];
      end
    end
  end

  assign push_valid = in_valid && emit;
  assign push_cmd   = encode_cp(cp);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      held_r    <= '0;
    end else begin
      pending_r <= pending_nxt;
      held_r    <= held_nxt;
    end
  end

endmodule

@@ design/u16u8_queue.sv @@
// ----------------------------------------------------------------------------
// u16u8_queue
// Short queue of encoded byte groups between the front and back ends.
// ----------------------------------------------------------------------------
module u16u8_queue
  import u16u8_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  cmd_t               push_cmd,
  output logic               pop_valid,
  input  logic               pop_ready,
  output cmd_t               pop_cmd,
  output logic [QLevelW-1:0] level
);

  cmd_t               mem_r [QDepth];
  logic [QPtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QLevelW-1:0] level_r, level_nxt;
  logic               do_push, do_pop;

  assign push_ready = (level_r != QLevelW'(QDepth));
  assign pop_valid  = (level_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign level      = level_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    level_nxt = level_r;
    if (do_push && !do_pop) level_nxt = level_r + 1'b1;
    else if (do_pop && !do_push) level_nxt = level_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      level_r <= level_nxt;
    end
  end

endmodule

@@ design/u16u8_back.sv @@
// ----------------------------------------------------------------------------
// u16u8_back
// Takes encoded byte groups from the queue and sends them one byte per beat
// through an output register.
// ----------------------------------------------------------------------------
module u16u8_back
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  cmd_t       pop_cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_utf8_byte,
  output logic       out_run_last
);

  cmd_t       cur_r;
  logic [1:0] idx_r;
  logic       busy_r;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       out_free, emit, is_last;

  assign out_free  = !out_valid_r || out_ready;
  assign is_last   = ({1'b0, idx_r} + 3'd1) == cur_r.cnt;
  assign emit      = busy_r && out_free;
  assign pop_ready = !busy_r || (emit && is_last);

  assign out_valid     = out_valid_r;
  assign out_utf8_byte = byte_r;
  assign out_run_last  = last_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= cur_r.bytes[idx_r];
      last_r <= is_last;
    end
    if (pop_valid && pop_ready) cur_r <= pop_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (pop_valid && pop_ready) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (emit) begin
        if (is_last) busy_r <= 1'b0;
        else idx_r <= idx_r + 1'b1;
      end
    end
  end

endmodule

@@ design/utf16_to_utf8_encoder_core.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_core
// UTF-16 to UTF-8 encoder: front end classifies and encodes units, a short
// queue decouples it from the back end, which sends one byte per beat.
//
//   channel   dir  payload                     handshake
//   in_ch     in   code_unit[15:0] string_last valid/ready
//   out_ch    out  utf8_byte[7:0]  run_last    valid/ready
//
// One unit may be accepted per cycle while the two-entry queue has room.
// The output port sends one byte per cycle while the sink is ready, so a unit
// yields 1 to 4 bytes (its byte count); a held surrogate yields no bytes.
// First byte path: queue entry, back-end group register, output register.
// Reset is synchronous, active low; no clearing pass.
// Either side may stall freely; the queue and output register absorb it.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_core
  import u16u8_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  u16u8_in_if.sink           in_ch,
  u16u8_out_if.source        out_ch
);

  logic               push_valid, push_ready;
  cmd_t               push_cmd;
  logic               pop_valid, pop_ready;
  cmd_t               pop_cmd;
  logic [QLevelW-1:0] q_level;

  u16u8_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_code_unit   (in_ch.code_unit),
    .in_string_last (in_ch.string_last),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd)
  );

  u16u8_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .level      (q_level)
  );

  u16u8_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_cmd       (pop_cmd),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_utf8_byte (out_ch.utf8_byte),
    .out_run_last  (out_ch.run_last)
  );

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= QLevelW'(QDepth))
    else $error("queue level out of range");

  a_level_track: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (q_level == $past(q_level) + QLevelW'($past(push_valid && push_ready))
                    - QLevelW'($past(pop_valid && pop_ready))))
    else $error("queue level does not follow push and pop");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && push_ready) |-> (push_cmd.cnt != 3'd0 && push_cmd.cnt <= 3'd4))
    else $error("pushed byte group has bad count");
`endif

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf16_to_utf8_encoder_core. A table of directed
// UTF-16 units (extremes, every byte length, paired, broken and trailing
// surrogates) is followed by random strings built mostly from valid text and
// surrogate pairs. An in-bench encoder predicts the UTF-8 byte stream, and
// every output beat is compared with the oldest predicted byte. Both sides
// idle at random, and the byte sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb
  import u16u8_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_beat_t;

  typedef struct packed {
    logic [15:0] unit;
    logic        last;
    logic        known;
    logic [2:0]  nbytes;
    logic [31:0] seq;
  } stim_row_t;

  localparam int NumRows     = 25;
  localparam int RandomUnits = 455;
  localparam int HoldAt      = 200;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 20;

  // seq holds the bytes first-out in its top byte; unknown rows use the encoder
  localparam stim_row_t DirectedRows [0:NumRows-1] = '{
    '{16'h0000, 1'b0, 1'b1, 3'd1, 32'h0000_0000},
    '{16'h007f, 1'b1, 1'b1, 3'd1, 32'h7f00_0000},
    '{16'h0080, 1'b0, 1'b1, 3'd2, 32'hc280_0000},
    '{16'h07ff, 1'b0, 1'b1, 3'd2, 32'hdfbf_0000},
    '{16'h0800, 1'b1, 1'b1, 3'd3, 32'he0a0_8000},
    '{16'hffff, 1'b0, 1'b1, 3'd3, 32'hefbf_bf00},
    '{16'hd800, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
    '{16'hdc00, 1'b1, 1'b1, 3'd4, 32'hf090_8080},
    '{16'hdbff, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
    '{16'hdfff, 1'b0, 1'b1, 3'd4, 32'hf48f_bfbf},
    '{16'hd800, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
    '{16'h0041, 1'b1, 1'b1, 3'd1, 32'h0000_0000},
    '{16'hdc00, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
    '{16'hd800, 1'b0, 1'b1, 3'd1, 32'h0000_0000},
    '{16'hdfff, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
    '{16'hdbff, 1'b1, 1'b1, 3'd1, 32'h0000_0000},
    '{16'hd800, 1'b1, 1'b1, 3'd3, 32'heda0_8000},
    '{16'hdfff, 1'b1, 1'b1, 3'd3, 32'hedbf_bf00},
    '{16'hdc00, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
    '{16'hdfff, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{16'he000, 1'b0, 1'b1, 3'd3, 32'hee80_8000},
    '{16'h5555, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{16'haaaa, 1'b1, 1'b0, 3'd0, 32'h0000_0000},
    '{16'hd955, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
    '{16'hdeaa, 1'b1, 1'b0, 3'd0, 32'h0000_0000}
  };

  logic clk;
  logic rst_n;

  u16u8_in_if  in_ch ();
  u16u8_out_if out_ch ();

  utf16_to_utf8_encoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  utf8_beat_t  pending_bytes [$];
  logic        sur_held;
  logic [9:0]  sur_bits;
  int          errors;
  int          units_sent;
  int          bytes_checked;
  int          pairs_joined;
  int          partners_swallowed;
  bit          in_idle;
  bit          out_idle;
  bit          sink_holding;
  bit          sink_hold_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int pick_gap(input bit idle);
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic encode_unit(input logic [15:0] unit, input logic last,
                             output int nbytes, output logic [3:0][7:0] seq);
    logic [20:0] cp;
    bit          emit;
    nbytes = 0;
    seq    = '0;
    emit   = 1'b1;
    cp     = {5'd0, unit};
    if (sur_held) begin
      sur_held = 1'b0;
      if (unit >= LowSurLo && unit <= SurHi) begin
        cp = {1'b0, sur_bits, unit[9:0]} + SuppBase;
        pairs_joined++;
      end else begin
        cp = '0;
        partners_swallowed++;
      end
      sur_bits = '0;
    end else if (unit >= SurLo && unit <= SurHi && !last) begin
      sur_held = 1'b1;
      sur_bits = unit[9:0];
      emit     = 1'b0;
    end
    if (emit) begin
      if (cp < 21'h80) begin
        nbytes = 1;
        seq[0] = cp[7:0];
      end else if (cp < 21'h800) begin
        nbytes = 2;
        seq[0] = 8'hc0 | 8'(cp >> 6);
        seq[1] = 8'h80 | 8'(cp & 21'h3f);
      end else if (cp < 21'h10000) begin
        nbytes = 3;
        seq[0] = 8'he0 | 8'(cp >> 12);
        seq[1] = 8'h80 | 8'((cp >> 6) & 21'h3f);
        seq[2] = 8'h80 | 8'(cp & 21'h3f);
      end else begin
        nbytes = 4;
        seq[0] = 8'hf0 | 8'((cp >> 18) & 21'h7);
        seq[1] = 8'h80 | 8'((cp >> 12) & 21'h3f);
        seq[2] = 8'h80 | 8'((cp >> 6) & 21'h3f);
        seq[3] = 8'h80 | 8'(cp & 21'h3f);
      end
    end
  endtask

  task automatic feed_unit(input logic [15:0] unit, input logic last, input logic known,
                           input int known_n, input logic [31:0] known_seq);
    int              gap;
    int              nbytes;
    logic [3:0][7:0] seq;
    gap = sink_holding ? 0 : pick_gap(in_idle);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.code_unit   <= unit;
    in_ch.string_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    units_sent++;
    encode_unit(unit, last, nbytes, seq);
    if (known) begin
      nbytes = known_n;
      for (int k = 0; k < 4; k++) seq[k] = known_seq[31-8*k -: 8];
    end
    for (int k = 0; k < nbytes; k++) pending_bytes.push_back('{seq[k], k == nbytes - 1});
  endtask

  initial begin
    int pick;
    int rand_units;
    int next_flip;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.code_unit   <= '0;
    in_ch.string_last <= 1'b0;
    sur_held           = 1'b0;
    sur_bits           = '0;
    in_idle            = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedRows[i])
      feed_unit(DirectedRows[i].unit, DirectedRows[i].last, DirectedRows[i].known,
                int'(DirectedRows[i].nbytes), DirectedRows[i].seq);

    rand_units = 0;
    next_flip  = 0;
    while (rand_units < RandomUnits) begin
      if (rand_units >= next_flip) begin
        in_idle    = $urandom_range(0, 2) != 0;
        next_flip += 50;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        feed_unit(16'($urandom_range(16'hd800, 16'hdbff)), 1'b0, 1'b0, 0, '0);
        feed_unit(16'($urandom_range(16'hdc00, 16'hdfff)), 1'($urandom_range(0, 1)),
                  1'b0, 0, '0);
        rand_units += 2;
      end else if (pick < 65) begin
        case ($urandom_range(0, 3))
          0: feed_unit(16'($urandom_range(16'h0000, 16'h007f)), 1'($urandom), 1'b0, 0, '0);
          1: feed_unit(16'($urandom_range(16'h0080, 16'h07ff)), 1'($urandom), 1'b0, 0, '0);
          2: feed_unit(16'($urandom_range(16'h0800, 16'hd7ff)), 1'($urandom), 1'b0, 0, '0);
          default: feed_unit(16'($urandom_range(16'he000, 16'hffff)), 1'($urandom),
                             1'b0, 0, '0);
        endcase
        rand_units += 1;
      end else if (pick < 75) begin
        feed_unit(16'($urandom_range(16'hd800, 16'hdfff)), 1'b1, 1'b0, 0, '0);
        rand_units += 1;
      end else if (pick < 90) begin
        feed_unit(16'($urandom_range(16'hd800, 16'hdfff)), 1'b0, 1'b0, 0, '0);
        feed_unit(16'($urandom), 1'($urandom), 1'b0, 0, '0);
        rand_units += 2;
      end else begin
        feed_unit(16'($urandom), 1'($urandom), 1'b0, 0, '0);
        rand_units += 1;
      end
    end
    // close any hold left open so its partner byte gets flushed
    if (sur_held) feed_unit(16'h0000, 1'b1, 1'b0, 0, '0);
    in_ch.valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Fed %0d UTF-16 units: %0d surrogate pairs joined, %0d partners swallowed.",
             units_sent, pairs_joined, partners_swallowed);
    $display("Checked %0d UTF-8 bytes against the predicted stream, %0d mismatches.",
             bytes_checked, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    int stall_left;
    int roll;
    int next_flip;
    int cyc;
    logic rdy;
    out_ch.ready  <= 1'b0;
    sink_holding   = 1'b0;
    sink_hold_done = 1'b0;
    out_idle       = 1'b1;
    stall_left     = 0;
    next_flip      = 0;
    cyc            = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!sink_hold_done && units_sent >= HoldAt) begin
        sink_holding  = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        sink_holding   = 1'b0;
        sink_hold_done = 1'b1;
      end else begin
        if (cyc >= next_flip) begin
          out_idle   = $urandom_range(0, 2) != 0;
          next_flip += 300;
        end
        if (stall_left > 0) begin
          rdy = 1'b0;
          stall_left--;
        end else begin
          rdy  = 1'b1;
          roll = $urandom_range(0, 99);
          if (out_idle && roll < 20) stall_left = $urandom_range(1, 3);
          else if (out_idle && roll < 23) stall_left = $urandom_range(10, 40);
        end
        out_ch.ready <= rdy;
        @(posedge clk);
        cyc++;
      end
    end
  end

  always @(posedge clk) begin
    utf8_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        $error("unexpected beat: utf8_byte %02h run_last %0b", out_ch.utf8_byte,
               out_ch.run_last);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.utf8_byte !== want.data) begin
          $error("utf8_byte: expected %02h, got %02h", want.data, out_ch.utf8_byte);
          errors++;
        end
        if (out_ch.run_last !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, out_ch.run_last);
          errors++;
        end
      end
    end
  end

endmodule

@@ utf16_to_utf8_encoder_core.f @@
design/u16u8_pkg.sv
design/u16u8_if.sv
design/u16u8_front.sv
design/u16u8_queue.sv
design/u16u8_back.sv
design/utf16_to_utf8_encoder_core.sv
tb/tb.sv
